>>> src/cgb_pkg.sv
// ----------------------------------------------------------------------------
// cgb_pkg: shared types and constants for the clipped 8x8 glyph blitter
// Request and result layouts, the queue entry passed from front to back end,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package cgb_pkg;

  localparam int GLYPH_DIM   = 8;
  localparam int GLYPH_PIX   = GLYPH_DIM * GLYPH_DIM;
  localparam int COL_W       = $clog2(GLYPH_DIM);
  localparam int COORD_W     = 16;
  localparam int COLOR_W     = 32;
  localparam int ADDR_W      = 24;
  localparam int DIM_W       = 13;
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = DIM_W'(480);

  typedef struct packed {
    logic [GLYPH_PIX-1:0]      glyph_bits;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [COLOR_W-1:0]        draw_color;
  } cgb_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_write;
  } cgb_out_t;

  // Classified glyph: visible set pixels plus origin_y * width (mod 2^ADDR_W)
  typedef struct packed {
    logic [GLYPH_PIX-1:0]      pix_mask;
    logic [ADDR_W-1:0]         row_base;
    logic signed [COORD_W-1:0] origin_x;
    logic [COLOR_W-1:0]        draw_color;
  } cgb_entry_t;

endpackage

>>> src/cgb_front.sv
// ----------------------------------------------------------------------------
// cgb_front: request intake and clipping
// Builds the mask of visible set pixels and the row base product, holds the
// result in one stage and hands it to the queue. Fully clipped glyphs drop.
// ----------------------------------------------------------------------------
module cgb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  cgb_pkg::cgb_in_t             in_data,
  input  logic [cgb_pkg::DIM_W-1:0]    scr_width,
  input  logic [cgb_pkg::DIM_W-1:0]    scr_height,
  output logic                         q_push,
  output cgb_pkg::cgb_entry_t          q_entry,
  input  logic                         q_full
);
  import cgb_pkg::*;

  localparam int PX_W = COORD_W + 1;

  logic                  f_valid_r, f_valid_nxt;
  cgb_entry_t            f_entry_r, f_entry_nxt;
  logic [GLYPH_DIM-1:0]  col_vis, row_vis;
  logic [GLYPH_PIX-1:0]  vis_mask;
  logic signed [COORD_W+DIM_W:0] prod;
  logic                  accept, advance, mask_nz;

  always_comb begin
    logic [PX_W-1:0] px;
    logic [PX_W-1:0] py;
    for (int c = 0; c < GLYPH_DIM; c++) begin
      px = {in_data.origin_x[COORD_W-1], in_data.origin_x} + PX_W'(c);
      py = {in_data.origin_y[COORD_W-1], in_data.origin_y} + PX_W'(c);
      col_vis[c] = !px[PX_W-1] &&
                   (px[COORD_W-1:0] < {{(COORD_W-DIM_W){1'b0}}, scr_width});
      row_vis[c] = !py[PX_W-1] &&
                   (py[COORD_W-1:0] < {{(COORD_W-DIM_W){1'b0}}, scr_height});
    end
    for (int r = 0; r < GLYPH_DIM; r++) begin
      for (int c = 0; c < GLYPH_DIM; c++) begin
        vis_mask[r*GLYPH_DIM+c] = in_data.glyph_bits[r*GLYPH_DIM+c] &
                                  row_vis[r] & col_vis[c];
      end
    end
  end

  assign prod = in_data.origin_y * $signed({1'b0, scr_width});

  assign mask_nz = |f_entry_r.pix_mask;
  // Advance when the queue has room, or drop a glyph with nothing visible
  assign advance = f_valid_r && (!q_full || !mask_nz);
  assign busy    = f_valid_r && !advance;
  assign accept  = start && !busy;
  assign q_push  = f_valid_r && mask_nz && !q_full;
  assign q_entry = f_entry_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    f_entry_nxt = f_entry_r;
    if (accept) begin
      f_valid_nxt            = 1'b1;
      f_entry_nxt.pix_mask   = vis_mask;
      f_entry_nxt.row_base   = prod[ADDR_W-1:0];
      f_entry_nxt.origin_x   = in_data.origin_x;
      f_entry_nxt.draw_color = in_data.draw_color;
    end else if (advance) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_entry_r <= f_entry_nxt;
  end

endmodule

>>> src/cgb_queue.sv
// ----------------------------------------------------------------------------
// cgb_queue: small FIFO between front and back end
// Holds classified glyphs so intake and pixel emission stall independently.
// ----------------------------------------------------------------------------
module cgb_queue #(
  parameter int DEPTH = cgb_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cgb_pkg::cgb_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output cgb_pkg::cgb_entry_t pop_data,
  output logic                empty
);
  import cgb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cgb_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/cgb_back.sv
// ----------------------------------------------------------------------------
// cgb_back: pixel write sequencer
// Walks the visible mask one pixel a cycle in raster order and emits one
// registered write per set bit, marking the final one.
// ----------------------------------------------------------------------------
module cgb_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  cgb_pkg::cgb_entry_t       q_data,
  output logic                      q_pop,
  input  logic [cgb_pkg::DIM_W-1:0] scr_width,
  output logic                      out_valid,
  output cgb_pkg::cgb_out_t         out_data
);
  import cgb_pkg::*;

  logic                  act_r, act_nxt;
  logic [GLYPH_PIX-1:0]  mask_r, mask_nxt;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [COLOR_W-1:0]    color_r, color_nxt;
  logic                  out_valid_r, out_valid_nxt;
  cgb_out_t              out_data_r, out_data_nxt;
  logic                  rest_zero, load;

  // Nothing beyond the current position means this pixel closes the glyph
  assign rest_zero = (mask_r[GLYPH_PIX-1:1] == '0);
  assign load      = !q_empty && (!act_r || rest_zero);
  assign q_pop     = load;

  always_comb begin
    act_nxt       = act_r;
    mask_nxt      = mask_r;
    base_nxt      = base_r;
    col_nxt       = col_r;
    color_nxt     = color_r;
    out_valid_nxt = act_r && mask_r[0];
    out_data_nxt.pixel_address = base_r + {{(ADDR_W-COL_W){1'b0}}, col_r};
    out_data_nxt.pixel_color   = color_r;
    out_data_nxt.last_write    = rest_zero;
    if (load) begin
      act_nxt   = 1'b1;
      mask_nxt  = q_data.pix_mask;
      base_nxt  = q_data.row_base +
                  {{(ADDR_W-COORD_W){q_data.origin_x[COORD_W-1]}}, q_data.origin_x};
      col_nxt   = '0;
      color_nxt = q_data.draw_color;
    end else if (act_r) begin
      act_nxt  = !rest_zero;
      mask_nxt = mask_r >> 1;
      col_nxt  = col_r + 1'b1;
      if (col_r == COL_W'(GLYPH_DIM - 1)) begin
        base_nxt = base_r + {{(ADDR_W-DIM_W){1'b0}}, scr_width};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r     <= mask_nxt;
    base_r     <= base_nxt;
    col_r      <= col_nxt;
    color_r    <= color_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/clipped_glyph_blit_8x8_top.sv
// ----------------------------------------------------------------------------
// clipped_glyph_blit_8x8_top: clipped 8x8 glyph blitter
// Turns one glyph bitmap, a signed screen origin and a color into framebuffer
// writes for every set pixel that lands inside the screen.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive start with in_data; the request is taken at a
//   clock edge where start is high and busy is low. busy rises only while the
//   intake stage holds a glyph that the queue cannot take yet.
//   Result channel: out_valid strobes for one cycle per pixel write, carrying
//   address (row * width + column), color and a last_write flag on the final
//   write of the glyph. Writes come out in raster order; the receiver cannot
//   stall, so every strobe must be taken.
//   Configuration: cfg_we with cfg_index 0 (screen width) or 1 (screen
//   height) writes cfg_wdata; other indexes are ignored. Values above the
//   maximum screen size saturate. Write only while the block is idle.
//   Path: a taken request is registered in the intake stage, written to the
//   queue, loaded into the back end and registered onto the result ports;
//   with the back end idle, positions scanned before the first visible one
//   delay the first write. The back end scans one position per cycle and
//   stops after the last visible pixel; a glyph with nothing visible gives
//   no writes and never reaches it. Requests keep flowing while the back end
//   works, until the queue and the intake stage are full.
//   Reset: clears the pipeline and queue and restores a 640 x 480 screen.
// ----------------------------------------------------------------------------
module clipped_glyph_blit_8x8_top #(
  parameter int QUEUE_DEPTH = cgb_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  cgb_pkg::cgb_in_t              in_data,
  input  logic                          cfg_we,
  input  logic [cgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cgb_pkg::DIM_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output cgb_pkg::cgb_out_t             out_data
);
  import cgb_pkg::*;

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [DIM_W-1:0] eff_width, eff_height;

  logic       q_push, q_full, q_pop, q_empty;
  cgb_entry_t q_push_data, q_pop_data;

  // Config register writes; unknown indexes drop
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_nxt  = cfg_wdata;
        REG_SCREEN_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_SCREEN_WIDTH;
      height_r <= RST_SCREEN_HEIGHT;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Saturate oversized screens for both clipping and stride
  assign eff_width  = (int'(width_r) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_r;
  assign eff_height = (int'(height_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_r;

  cgb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .scr_width  (eff_width),
    .scr_height (eff_height),
    .q_push     (q_push),
    .q_entry    (q_push_data),
    .q_full     (q_full)
  );

  cgb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  cgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .scr_width (eff_width),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the clipped 8x8 glyph blitter
// Sends glyph requests through the start/busy handshake and predicts, for
// each one, the clipped framebuffer writes in raster order. A checker compares
// every out_valid strobe against the oldest predicted write. Directed tests
// cover the screen edges, empty and tiny screens, size saturation and ignored
// register indexes; random phases then sweep several screen sizes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cgb_pkg::*;

  // Indexes that map to no register; writes there must not change anything.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

  localparam int SETTLE_CYCLES  = 16;    // intake latency plus margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request and no write
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 74;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  cgb_in_t  in_data;
  logic     cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;
  logic     out_valid;
  cgb_out_t out_data;

  // Shadow copy of the screen registers, updated as they are written.
  logic [DIM_W-1:0] scr_width;
  logic [DIM_W-1:0] scr_height;

  // Writes predicted for accepted glyphs, oldest first.
  cgb_out_t pending_writes[$];
  int       fail_count;
  int       stall_cycles;
  bit       gaps_on;

  clipped_glyph_blit_8x8_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Effective screen extent: register values above the maximum saturate.
  function automatic int eff_width();
    return (scr_width > MAX_WIDTH) ? MAX_WIDTH : int'(scr_width);
  endfunction

  function automatic int eff_height();
    return (scr_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(scr_height);
  endfunction

  // Scan the bitmap row by row, column by column; keep each set bit whose
  // pixel lands on the screen and flag the last kept one.
  function automatic void predict_glyph_writes(cgb_in_t g);
    cgb_out_t wr_list[GLYPH_PIX];
    int       n;
    int       w;
    int       h;
    int       ox;
    int       oy;
    int       px;
    int       py;
    n  = 0;
    w  = eff_width();
    h  = eff_height();
    ox = $signed(g.origin_x);
    oy = $signed(g.origin_y);
    for (int r = 0; r < GLYPH_DIM; r++) begin
      py = oy + r;
      for (int c = 0; c < GLYPH_DIM; c++) begin
        px = ox + c;
        if (g.glyph_bits[r * GLYPH_DIM + c] && px >= 0 && px < w && py >= 0 && py < h) begin
          wr_list[n].pixel_address = ADDR_W'(py * w + px);
          wr_list[n].pixel_color   = g.draw_color;
          wr_list[n].last_write    = 1'b0;
          n++;
        end
      end
    end
    if (n > 0) wr_list[n - 1].last_write = 1'b1;
    for (int i = 0; i < n; i++) pending_writes.push_back(wr_list[i]);
  endfunction

  // Present one request and hold it until the handshake takes it. Start is
  // left high afterwards so back-to-back requests never toggle it in one step;
  // a gap or settle_screen() drops it.
  task automatic blit_glyph(input cgb_in_t g);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= g;
    do @(posedge clk); while (busy);
    predict_glyph_writes(g);
  endtask

  task automatic blit_at(input logic [GLYPH_PIX-1:0] bits, input int x, input int y,
                         input logic [COLOR_W-1:0] color);
    cgb_in_t g;
    g.glyph_bits = bits;
    g.origin_x   = COORD_W'(x);
    g.origin_y   = COORD_W'(y);
    g.draw_color = color;
    blit_glyph(g);
  endtask

  // Drop start, wait for every predicted write, then let invisible glyphs
  // still in the intake stage drain before touching the registers.
  task automatic settle_screen();
    start <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pulse the write enable for one edge, then release it so consecutive
  // writes never lower and raise it in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_SCREEN_WIDTH) scr_width = val;
    else if (idx == REG_SCREEN_HEIGHT) scr_height = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
  endtask

  // Mix of bitmap densities: dense, sparse, single pixels, empty and full.
  function automatic logic [GLYPH_PIX-1:0] random_glyph();
    logic [GLYPH_PIX-1:0] a;
    logic [GLYPH_PIX-1:0] b;
    logic [GLYPH_PIX-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0:           return '0;
      1:           return '1;
      2, 3:        return GLYPH_PIX'(1) << $urandom_range(0, GLYPH_PIX - 1);
      4, 5, 6, 7:  return a & b & c;
      8, 9:        return a | b;
      default:     return a;
    endcase
  endfunction

  // Origins mostly straddle the visible area so clipping hits every edge;
  // some take the whole signed range.
  function automatic logic [COORD_W-1:0] random_origin(input int extent);
    if ($urandom_range(0, 6) == 0) return COORD_W'($urandom);
    return COORD_W'(int'($urandom_range(0, extent + 11)) - 9);
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(0, 7))
      0:       return DIM_W'($urandom_range(1, 8));
      1, 2:    return DIM_W'($urandom_range(9, 64));
      3, 4, 5: return DIM_W'($urandom_range(65, MAX_WIDTH));
      6:       return DIM_W'($urandom_range(MAX_WIDTH + 1, 8191));
      default: return DIM_W'(MAX_WIDTH);
    endcase
  endfunction

  // ---- tests ---------------------------------------------------------------

  // Reset screen is 640 x 480: hit each border, fully outside cases and
  // the full and empty bitmaps.
  task automatic test_reset_screen();
    blit_at('1, 0, 0, 32'hFFFF_FFFF);
    blit_at('0, 10, 10, 32'h1234_5678);
    blit_at('1, -4, -4, 32'h0000_0000);          // screen rows and columns 0 to 3 stay visible
    blit_at('1, 636, 476, 32'hA5A5_A5A5);        // bottom-right corner clip
    blit_at('1, -8, 100, 32'h5A5A_5A5A);         // just left of the screen
    blit_at('1, 640, 100, 32'h0F0F_0F0F);        // just right of the screen
    blit_at('1, 100, -8, 32'hF0F0_F0F0);         // just above
    blit_at('1, 100, 480, 32'h8000_0001);        // just below
    blit_at('1, -32768, -32768, 32'hDEAD_BEEF);
    blit_at('1, 32767, 32767, 32'hCAFE_F00D);
    blit_at(64'h8000_0000_0000_0000, -7, -7, 32'h7FFF_FFFE);
    blit_at(64'h8000_0000_0000_0001, 632, 472, 32'h0000_FFFF);
    settle_screen();
  endtask

  // One-pixel screen, then zero width and zero height.
  task automatic test_tiny_screen();
    set_screen(DIM_W'(1), DIM_W'(1));
    blit_at('1, 0, 0, 32'h1111_1111);
    blit_at('1, -7, -7, 32'h2222_2222);
    settle_screen();
    write_reg(REG_SCREEN_WIDTH, '0);
    blit_at('1, 0, 0, 32'h3333_3333);
    settle_screen();
    set_screen(DIM_W'(5), '0);
    blit_at('1, 0, 0, 32'h4444_4444);
    settle_screen();
  endtask

  // Values above the maximum clamp both the clip and the row stride.
  task automatic test_saturated_screen();
    set_screen('1, '1);
    blit_at('1, 4090, 4090, 32'h5555_5555);
    settle_screen();
    set_screen(DIM_W'(MAX_WIDTH), DIM_W'(MAX_HEIGHT + 1));
    blit_at('1, 4090, 4090, 32'h6666_6666);
    settle_screen();
  endtask

  // Unused indexes leave the screen as it was.
  task automatic test_ignored_index();
    write_reg(REG_UNUSED_2, '0);
    write_reg(REG_UNUSED_3, DIM_W'(3));
    blit_at('1, 0, 0, 32'h7777_7777);
    settle_screen();
  endtask

  // Random glyphs over several screen sizes, extremes among them; the last
  // phase runs at full rate with no request gaps.
  task automatic test_random_screens();
    cgb_in_t g;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_screen(DIM_W'(13), DIM_W'(9));
        1:       set_screen('1, '1);
        4:       set_screen(DIM_W'(MAX_WIDTH), DIM_W'(2));
        5:       set_screen(RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT);
        default: set_screen(random_dim(), random_dim());
      endcase
      gaps_on = (p != RANDOM_PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        g.glyph_bits = random_glyph();
        g.origin_x   = random_origin(eff_width());
        g.origin_y   = random_origin(eff_height());
        g.draw_color = $urandom;
        blit_glyph(g);
      end
      settle_screen();
    end
  endtask

  // ---- result checker --------------------------------------------------------

  // Compare each strobe with the oldest predicted write, field by field.
  always @(posedge clk) begin
    cgb_out_t exp_wr;
    if (rst_n && out_valid) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write: address %0h color %0h last %0b",
               out_data.pixel_address, out_data.pixel_color, out_data.last_write);
        fail_count++;
      end else begin
        exp_wr = pending_writes.pop_front();
        if (out_data.pixel_address !== exp_wr.pixel_address) begin
          $error("pixel_address: expected %0h, got %0h",
                 exp_wr.pixel_address, out_data.pixel_address);
          fail_count++;
        end
        if (out_data.pixel_color !== exp_wr.pixel_color) begin
          $error("pixel_color: expected %0h, got %0h",
                 exp_wr.pixel_color, out_data.pixel_color);
          fail_count++;
        end
        if (out_data.last_write !== exp_wr.last_write) begin
          $error("last_write: expected %0b, got %0b",
                 exp_wr.last_write, out_data.last_write);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles where neither a request nor a write moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---- sequence ------------------------------------------------------------

  initial begin
    int missing;
    gaps_on      = 1'b1;
    scr_width    = RST_SCREEN_WIDTH;
    scr_height   = RST_SCREEN_HEIGHT;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_screen();
    test_tiny_screen();
    test_saturated_screen();
    test_ignored_index();
    test_random_screens();

    // settle_screen() already waited out every write; hold a little longer
    // to catch any stray strobe.
    repeat (SETTLE_CYCLES) @(posedge clk);
    missing = pending_writes.size();
    if (missing != 0) begin
      $error("%0d predicted writes never arrived", missing);
    end
    if (fail_count == 0 && missing == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
